// ----- rtl/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared types and codes for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned ENTRY_W = 3 * COORD_W;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PRD  = 13'b0000000000010,
    S_MUL  = 13'b0000000000100,
    S_ABS  = 13'b0000000001000,
    S_NORM = 13'b0000000010000,
    S_SQ   = 13'b0000000100000,
    S_SQRT = 13'b0000001000000,
    S_DLD  = 13'b0000010000000,
    S_DIV  = 13'b0000100000000,
    S_NRD  = 13'b0001000000000,
    S_NWR  = 13'b0010000000000,
    S_ORD  = 13'b0100000000000,
    S_OWR  = 13'b1000000000000
  } state_t;

endpackage

// ----- rtl/vertex_normal_accumulator.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Builds smooth vertex normals by summing unit face normals into a vertex
// store, with position and normal-sum memories and a sequential datapath.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input channel (in_valid / in_ready) and carry
// a mode. A load request writes a vertex position and clears its normal sum
// in the cycle it is accepted. A triangle request reads the three corner
// positions, forms the cross product with one shared 25 x 25 multiplier,
// normalises it with a one-bit-per-cycle shifter, squares it, takes an
// integer square root one result bit per cycle and divides each component by
// restoring division, then read-modify-writes the three corner sums. No new
// request is accepted until a triangle is finished. A read request returns
// one result on the output channel (out_valid / out_ready), held in an
// output register, so the next request is accepted while the result still
// waits. If the receiver stalls, a second read waits until the output
// register is free. Synchronous reset returns the control to idle and
// empties the output register; the memory contents are undefined until each
// entry is written by a load request.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [IDX_W-1:0]          first_index,
  input  logic [IDX_W-1:0]          second_index,
  input  logic [IDX_W-1:0]          third_index,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          vertex_id,
  output logic signed [COORD_W-1:0] normal_x,
  output logic signed [COORD_W-1:0] normal_y,
  output logic signed [COORD_W-1:0] normal_z
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // Maps a request index onto a memory address of the configured depth.
  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] idx);
    logic [16:0] ext;
    ext = 17'(idx);
    return ext[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  // Memories and their ports.
  logic [ENTRY_W-1:0] pos_mem [MAX_VERTICES];
  logic [ENTRY_W-1:0] nrm_mem [MAX_VERTICES];
  logic               pos_we, pos_re, nrm_we, nrm_re;
  logic [AW-1:0]      pos_waddr, pos_raddr, nrm_waddr, nrm_raddr;
  logic [ENTRY_W-1:0] pos_wdata, nrm_wdata, pos_rdata, nrm_rdata;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pos_re) begin
      pos_rdata <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    if (nrm_re) begin
      nrm_rdata <= nrm_mem[nrm_raddr];
    end
  end

  // Control and datapath registers.
  state_t                     state;
  logic [2:0]                 cnt;
  logic [IDX_W-1:0]           idx_a, idx_b, idx_c;
  logic                       rd_valid;
  logic signed [COORD_W-1:0]  pa [3];
  logic signed [COORD_W-1:0]  pb [3];
  logic signed [COORD_W-1:0]  pc [3];
  logic signed [49:0]         prod;
  logic signed [50:0]         cr [3];
  logic [49:0]                mag [3];
  logic [2:0]                 sgn;
  logic [59:0]                sq;
  logic [61:0]                sum;
  logic [63:0]                num, res, bitreg;
  logic [30:0]                nrm;
  logic [44:0]                rem, dvs;
  logic [14:0]                quo;
  logic [3:0]                 bitcnt;
  logic [1:0]                 comp;
  logic signed [15:0]         unit [3];

  // Combinational helpers.
  logic                      accept;
  logic                      out_load;
  logic signed [24:0]        e1 [3];
  logic signed [24:0]        e2 [3];
  logic signed [24:0]        ma, mb;
  logic [2:0]                pidx;
  logic [49:0]               orv;
  logic [63:0]               trial;
  logic                      ge;
  logic [14:0]               quo_next;
  logic [61:0]               sum_next;
  logic [IDX_W-1:0]          corner;
  logic [COORD_W-1:0]        sat [3];

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  // The output register takes a new result when it is empty or being drained.
  assign out_load = (state == S_OWR) && (!out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 25'(pb[i]) - 25'(pa[i]);
      e2[i] = 25'(pc[i]) - 25'(pa[i]);
    end
  end

  always_comb begin
    case (cnt)
      3'd0:    begin ma = e1[1]; mb = e2[2]; end
      3'd1:    begin ma = e2[1]; mb = e1[2]; end
      3'd2:    begin ma = e1[2]; mb = e2[0]; end
      3'd3:    begin ma = e2[2]; mb = e1[0]; end
      3'd4:    begin ma = e1[0]; mb = e2[1]; end
      default: begin ma = e2[0]; mb = e1[1]; end
    endcase
  end

  assign pidx     = cnt - 3'd1;
  assign orv      = mag[0] | mag[1] | mag[2];
  assign trial    = res + bitreg;
  assign ge       = rem >= dvs;
  assign quo_next = {quo[13:0], ge};
  assign sum_next = sum + 62'(sq);

  always_comb begin
    case (cnt)
      3'd0:    corner = idx_a;
      3'd1:    corner = idx_b;
      default: corner = idx_c;
    endcase
  end

  // Saturating add of the unit normal to the corner sum just read.
  always_comb begin
    logic signed [24:0] s;
    for (int i = 0; i < 3; i++) begin
      s = 25'($signed(nrm_rdata[ENTRY_W-1-COORD_W*i -: COORD_W])) + 25'(unit[i]);
      if (s > 25'sd8388607) begin
        sat[i] = 24'h7FFFFF;
      end else if (s < -25'sd8388608) begin
        sat[i] = 24'h800000;
      end else begin
        sat[i] = s[COORD_W-1:0];
      end
    end
  end

  // Rounded dividend for one component of the unit normal.
  function automatic logic [44:0] dividend(input logic [29:0] m, input logic [30:0] n);
    return 45'({m, 14'b0}) + 45'(n[30:1]);
  endfunction

  // Memory port control.
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = addr_of(first_index);
    pos_wdata = {pos_x, pos_y, pos_z};
    pos_re    = 1'b0;
    pos_raddr = addr_of(corner);
    nrm_we    = 1'b0;
    nrm_waddr = addr_of(first_index);
    nrm_wdata = '0;
    nrm_re    = 1'b0;
    nrm_raddr = addr_of(corner);
    unique case (state)
      S_IDLE: begin
        if (accept && mode_t'(mode) == MODE_LOAD && in_range(first_index)) begin
          pos_we = 1'b1;
          nrm_we = 1'b1;
        end
      end
      S_PRD: begin
        pos_re = (cnt < 3'd3);
      end
      S_NRD, S_ORD: begin
        nrm_re = 1'b1;
      end
      S_NWR: begin
        nrm_we    = 1'b1;
        nrm_waddr = addr_of(corner);
        nrm_wdata = {sat[0], sat[1], sat[2]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx_a    <= first_index;
            idx_b    <= second_index;
            idx_c    <= third_index;
            rd_valid <= in_range(first_index);
            cnt      <= '0;
            case (mode_t'(mode))
              MODE_TRI: begin
                if (in_range(first_index) && in_range(second_index)
                    && in_range(third_index)) begin
                  state <= S_PRD;
                end
              end
              MODE_READ: state <= S_ORD;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_PRD: begin
          cnt <= cnt + 3'd1;
          for (int i = 0; i < 3; i++) begin
            case (cnt)
              3'd1:    pa[i] <= $signed(pos_rdata[ENTRY_W-1-COORD_W*i -: COORD_W]);
              3'd2:    pb[i] <= $signed(pos_rdata[ENTRY_W-1-COORD_W*i -: COORD_W]);
              3'd3:    pc[i] <= $signed(pos_rdata[ENTRY_W-1-COORD_W*i -: COORD_W]);
              default: begin end
            endcase
          end
          if (cnt == 3'd3) begin
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // One product a cycle; each product is folded in on the next cycle.
          prod <= ma * mb;
          cnt  <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            if (!pidx[0]) begin
              cr[pidx[2:1]] <= 51'(prod);
            end else begin
              cr[pidx[2:1]] <= cr[pidx[2:1]] - 51'(prod);
            end
          end
          if (cnt == 3'd6) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            sgn[i] <= cr[i][50];
            mag[i] <= cr[i][50] ? 50'(-cr[i]) : 50'(cr[i]);
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (orv == '0) begin
            state <= S_IDLE;
          end else if (|orv[49:30]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!orv[29]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            cnt   <= '0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 3'd1;
          if (cnt < 3'd3) begin
            sq <= mag[cnt[1:0]][29:0] * mag[cnt[1:0]][29:0];
          end
          if (cnt != 3'd0) begin
            sum <= sum_next;
          end
          if (cnt == 3'd3) begin
            num    <= 64'(sum_next);
            res    <= '0;
            bitreg <= 64'h4000_0000_0000_0000;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (num >= trial) begin
            num <= num - trial;
            res <= (res >> 1) + bitreg;
          end else begin
            res <= res >> 1;
          end
          bitreg <= bitreg >> 2;
          if (bitreg == 64'd1) begin
            state <= S_DLD;
          end
        end
        S_DLD: begin
          nrm    <= res[30:0];
          rem    <= dividend(mag[0][29:0], res[30:0]);
          dvs    <= {res[30:0], 14'b0};
          quo    <= '0;
          bitcnt <= 4'd14;
          comp   <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dvs;
          end
          quo    <= quo_next;
          dvs    <= dvs >> 1;
          bitcnt <= bitcnt - 4'd1;
          if (bitcnt == 4'd0) begin
            unit[comp] <= sgn[comp] ? -16'(quo_next) : 16'(quo_next);
            if (comp == 2'd2) begin
              cnt   <= '0;
              state <= S_NRD;
            end else begin
              comp   <= comp + 2'd1;
              rem    <= dividend(mag[comp + 2'd1][29:0], nrm);
              dvs    <= {nrm, 14'b0};
              quo    <= '0;
              bitcnt <= 4'd14;
            end
          end
        end
        S_NRD: begin
          state <= S_NWR;
        end
        S_NWR: begin
          if (cnt == 3'd2) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_NRD;
          end
        end
        S_ORD: begin
          state <= S_OWR;
        end
        S_OWR: begin
          if (out_load) begin
            vertex_id <= idx_a;
            normal_x  <= rd_valid ? $signed(nrm_rdata[71:48]) : '0;
            normal_y  <= rd_valid ? $signed(nrm_rdata[47:24]) : '0;
            normal_z  <= rd_valid ? $signed(nrm_rdata[23:0])  : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives load, triangle, read and unused requests into the accumulator. A
// predictor of its own in this file computes the normal sum of every vertex,
// and each read result is checked field by field against the oldest
// expected read.
// ----------------------------------------------------------------------------
module testbench;
  import vna_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
  } vec3_t;

  typedef struct {
    logic [IDX_W-1:0]          id;
    logic signed [COORD_W-1:0] nx, ny, nz;
  } normal_read_t;

  localparam int unsigned VERTS = 4096;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                mode = MODE_NONE;
  logic [IDX_W-1:0]          first_index = '0;
  logic [IDX_W-1:0]          second_index = '0;
  logic [IDX_W-1:0]          third_index = '0;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic signed [COORD_W-1:0] pos_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [IDX_W-1:0]          vertex_id;
  logic signed [COORD_W-1:0] normal_x;
  logic signed [COORD_W-1:0] normal_y;
  logic signed [COORD_W-1:0] normal_z;

  vertex_normal_accumulator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .first_index  (first_index),
    .second_index (second_index),
    .third_index  (third_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_id    (vertex_id),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z)
  );

  // Our own copy of the two vertex stores, plus a record of which vertices
  // have been loaded, so that no request ever touches an unwritten entry.
  vec3_t          position_mem [VERTS];
  vec3_t          normal_mem   [VERTS];
  bit             loaded       [VERTS];
  int             loaded_list  [$];
  normal_read_t   pending_reads[$];
  int             mismatches = 0;
  bit             quiet = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Guard against a hung block.
  initial begin
    #1500000;
    $display("Mismatches found");
    $finish;
  end

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(logic signed [COORD_W-1:0] acc,
                                                       longint add);
    longint s;
    s = longint'(acc) + add;
    if (s > 64'sd8388607) s = 64'sd8388607;
    if (s < -64'sd8388608) s = -64'sd8388608;
    return s[COORD_W-1:0];
  endfunction

  // Unit face normal of a triangle, added with saturation to its corners.
  function automatic void accumulate_face(int a, int b, int c);
    longint          e1[3], e2[3], cr[3], unit[3];
    longint unsigned mag[3];
    longint unsigned m, sq, nrm, q;
    int              corners[3];
    e1[0] = longint'(position_mem[b].x) - longint'(position_mem[a].x);
    e1[1] = longint'(position_mem[b].y) - longint'(position_mem[a].y);
    e1[2] = longint'(position_mem[b].z) - longint'(position_mem[a].z);
    e2[0] = longint'(position_mem[c].x) - longint'(position_mem[a].x);
    e2[1] = longint'(position_mem[c].y) - longint'(position_mem[a].y);
    e2[2] = longint'(position_mem[c].z) - longint'(position_mem[a].z);
    cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
    cr[1] = e1[2] * e2[0] - e2[2] * e1[0];
    cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
      if (mag[i] > m) m = mag[i];
    end
    // A degenerate triangle contributes nothing.
    if (m == 0) return;
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sq  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    nrm = int_sqrt(sq);
    if (nrm == 0) return;
    for (int i = 0; i < 3; i++) begin
      q       = (mag[i] * 16384 + (nrm >> 1)) / nrm;
      unit[i] = (cr[i] < 0) ? -longint'(q) : longint'(q);
    end
    corners[0] = a;
    corners[1] = b;
    corners[2] = c;
    for (int k = 0; k < 3; k++) begin
      normal_mem[corners[k]].x = sat_add(normal_mem[corners[k]].x, unit[0]);
      normal_mem[corners[k]].y = sat_add(normal_mem[corners[k]].y, unit[1]);
      normal_mem[corners[k]].z = sat_add(normal_mem[corners[k]].z, unit[2]);
    end
  endfunction

  // Applies one accepted request to the predicted stores.
  function automatic void predict_request(logic [1:0] m, int i0, int i1, int i2, vec3_t p);
    normal_read_t r;
    case (m)
      MODE_LOAD: begin
        position_mem[i0] = p;
        normal_mem[i0]   = '{x: '0, y: '0, z: '0};
        if (!loaded[i0]) begin
          loaded[i0] = 1'b1;
          loaded_list.push_back(i0);
        end
      end
      MODE_TRI: begin
        accumulate_face(i0, i1, i2);
      end
      MODE_READ: begin
        r.id = i0[IDX_W-1:0];
        r.nx = normal_mem[i0].x;
        r.ny = normal_mem[i0].y;
        r.nz = normal_mem[i0].z;
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Sends one request, waits for its acceptance, and then perhaps idles for
  // a random burst before the next one.
  task automatic send_request(logic [1:0] m, int i0, int i1, int i2, vec3_t p);
    int gap;
    mode         <= m;
    first_index  <= i0[IDX_W-1:0];
    second_index <= i1[IDX_W-1:0];
    third_index  <= i2[IDX_W-1:0];
    pos_x        <= p.x;
    pos_y        <= p.y;
    pos_z        <= p.z;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(m, i0, i1, i2, p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic vec3_t rand_pos();
    vec3_t p;
    p.x = COORD_W'($urandom);
    p.y = COORD_W'($urandom);
    p.z = COORD_W'($urandom);
    // Sometimes keep coordinates small so that the normalising shift works
    // upwards as well as downwards.
    if ($urandom_range(0, 2) == 0) begin
      p.x = $signed(p.x) >>> $urandom_range(8, 22);
      p.y = $signed(p.y) >>> $urandom_range(8, 22);
      p.z = $signed(p.z) >>> $urandom_range(8, 22);
    end
    return p;
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Receiver side: random stall bursts until the quiet tail of the run.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result is compared with the oldest expected read.
  always @(posedge clk) begin
    normal_read_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: id %0d normal %0d %0d %0d",
                   vertex_id, normal_x, normal_y, normal_z);
      end else begin
        exp_r = pending_reads.pop_front();
        if (vertex_id !== exp_r.id || normal_x !== exp_r.nx ||
            normal_y !== exp_r.ny || normal_z !== exp_r.nz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected id %0d normal %0d %0d %0d, got id %0d normal %0d %0d %0d",
                     exp_r.id, exp_r.nx, exp_r.ny, exp_r.nz,
                     vertex_id, normal_x, normal_y, normal_z);
        end
      end
    end
  end

  // Extreme indices and coordinates, a tiny and a huge triangle, repeated
  // corners, a collinear triangle, and the unused mode.
  task automatic test_directed();
    vec3_t p;
    vec3_t z;
    z = '{x: '0, y: '0, z: '0};
    send_request(MODE_LOAD, 0, 4095, 4095, '{x: 24'sh7FFFFF, y: 24'sh800000, z: 24'sh7FFFFF});
    send_request(MODE_LOAD, 4095, 0, 0, '{x: 24'sh800000, y: 24'sh7FFFFF, z: 24'sh800000});
    send_request(MODE_LOAD, 1, 0, 0, '{x: 24'sh800000, y: 24'sh800000, z: 24'sh7FFFFF});
    send_request(MODE_LOAD, 2, 0, 0, z);
    send_request(MODE_LOAD, 3, 0, 0, '{x: 24'sd1, y: 24'sd0, z: 24'sd0});
    send_request(MODE_LOAD, 4, 0, 0, '{x: 24'sd0, y: 24'sd1, z: 24'sd0});
    send_request(MODE_LOAD, 5, 0, 0, '{x: 24'sd2, y: 24'sd0, z: 24'sd0});
    // The largest edges and cross product the fields allow.
    send_request(MODE_TRI, 0, 4095, 1, z);
    // A one-unit triangle needs the full upward normalisation.
    send_request(MODE_TRI, 2, 3, 4, z);
    // Repeated corners and a collinear triangle add nothing.
    send_request(MODE_TRI, 2, 2, 3, z);
    send_request(MODE_TRI, 3, 3, 3, z);
    send_request(MODE_TRI, 2, 3, 5, z);
    send_request(MODE_NONE, 4095, 4095, 4095, '{x: '1, y: '1, z: '1});
    for (int i = 0; i < 6; i++) send_request(MODE_READ, i, 4095, 4095, z);
    send_request(MODE_READ, 4095, 0, 0, z);
    // Reloading a vertex clears its sum.
    p = rand_pos();
    send_request(MODE_LOAD, 3, 0, 0, p);
    send_request(MODE_READ, 3, 0, 0, z);
  endtask

  // One fixed triangle whose unit normal points equally along +z and -y, so
  // its corner sums run into the upper clamp on z and the lower clamp on y.
  task automatic test_saturation();
    vec3_t       z;
    int unsigned side;
    z    = '{x: '0, y: '0, z: '0};
    side = $urandom_range(1, 8388607);
    send_request(MODE_LOAD, 100, 0, 0, z);
    send_request(MODE_LOAD, 101, 0, 0,
                 '{x: COORD_W'($urandom_range(1, 8388607)), y: 24'sd0, z: 24'sd0});
    send_request(MODE_LOAD, 102, 0, 0,
                 '{x: 24'sd0, y: COORD_W'(side), z: COORD_W'(side)});
    for (int n = 0; n < 740; n++) begin
      send_request(MODE_TRI, 100, 101, 102, z);
      if ($urandom_range(0, 40) == 0)
        send_request(MODE_READ, 100 + $urandom_range(0, 2), $urandom, $urandom, z);
    end
    for (int i = 100; i < 103; i++) send_request(MODE_READ, i, 0, 0, z);
  endtask

  // Random mix of all modes over the whole index range.
  task automatic test_random_mix(int count);
    int    sel;
    vec3_t p;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      p   = rand_pos();
      if (sel < 6) begin
        send_request(MODE_LOAD, $urandom_range(0, 4095), $urandom, $urandom, p);
      end else if (sel < 14) begin
        send_request(MODE_TRI, pick_loaded(), pick_loaded(), pick_loaded(), p);
      end else if (sel < 19) begin
        send_request(MODE_READ, pick_loaded(), $urandom, $urandom, p);
      end else begin
        send_request(MODE_NONE, $urandom, $urandom, $urandom, p);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random_mix(280);
    // Back-to-back requests with the receiver always ready.
    quiet = 1'b1;
    test_random_mix(80);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vna_pkg.sv
rtl/vertex_normal_accumulator.sv
sim/testbench.sv
